>>> hw/rtl/swsfr_pkg.sv
`timescale 1ns / 1ps

package swsfr_pkg;

    // Default sizing
    localparam int MAX_WINDOW_DEF = 16;
    localparam int SEQ_BITS_DEF   = 32;
    localparam int DATA_BITS_DEF  = 64;

    // Configuration register fields
    localparam int WIN_W   = 5;
    localparam int LIMIT_W = 3;
    localparam int DUP_W   = 3;

    localparam logic [WIN_W-1:0]   WINDOW_RST = 5'd4;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 3'd4;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN  = 3'd2;
    localparam logic [DUP_W-1:0]   DUP_MAX    = 3'd7;

    // Register index, taken from byte address bit 2
    localparam logic REG_WINDOW    = 1'b0;
    localparam logic REG_DUP_LIMIT = 1'b1;

    // Function codes on the command channel
    localparam logic [1:0] FUNC_SEND  = 2'd0;
    localparam logic [1:0] FUNC_ACK   = 2'd1;
    localparam logic [1:0] FUNC_TIMER = 2'd2;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_TIMEOUT,
        OP_NONE
    } op_t;

endpackage

>>> hw/rtl/swsfr_ram.sv
`timescale 1ns / 1ps

module swsfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/swsfr_front.sv
`timescale 1ns / 1ps

module swsfr_front #(
    parameter int SEQ_BITS  = 32,
    parameter int DATA_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // command side
    input  logic                 take,
    input  logic [1:0]           func,
    input  logic [DATA_BITS-1:0] payload,
    input  logic [SEQ_BITS-1:0]  ack_seq,
    input  logic                 ack_checksum_ok,
    output logic                 room,
    // queue head toward the back end
    output logic                 q_valid,
    output swsfr_pkg::op_t       q_op,
    output logic [DATA_BITS-1:0] q_payload,
    output logic [SEQ_BITS-1:0]  q_ack,
    output logic                 q_ck_ok,
    input  logic                 q_pop
);

    import swsfr_pkg::*;

    localparam int QDEPTH = 2;

    op_t                  op_q      [QDEPTH];
    logic [DATA_BITS-1:0] payload_q [QDEPTH];
    logic [SEQ_BITS-1:0]  ack_q     [QDEPTH];
    logic                 ck_q      [QDEPTH];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    op_t        op_class;

    // Decode the function code
    always_comb
    begin
        case (func)
            FUNC_SEND:  op_class = OP_SEND;
            FUNC_ACK:   op_class = OP_ACK;
            FUNC_TIMER: op_class = OP_TIMEOUT;
            default:    op_class = OP_NONE;
        endcase
    end

    assign room    = (count_reg != 2'(QDEPTH));
    assign push    = take && room;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_pop && q_valid;

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg]      <= op_class;
            payload_q[wr_ptr_reg] <= payload;
            ack_q[wr_ptr_reg]     <= ack_seq;
            ck_q[wr_ptr_reg]      <= ack_checksum_ok;
        end
    end

    assign q_op      = op_q[rd_ptr_reg];
    assign q_payload = payload_q[rd_ptr_reg];
    assign q_ack     = ack_q[rd_ptr_reg];
    assign q_ck_ok   = ck_q[rd_ptr_reg];

endmodule

>>> hw/rtl/swsfr_back.sv
`timescale 1ns / 1ps

module swsfr_back #(
    parameter int MAX_WINDOW = 16,
    parameter int SEQ_BITS   = 32,
    parameter int DATA_BITS  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic [swsfr_pkg::WIN_W-1:0]   cfg_window,
    input  logic [swsfr_pkg::LIMIT_W-1:0] cfg_limit,
    // queue head
    input  logic                          q_valid,
    input  swsfr_pkg::op_t                q_op,
    input  logic [DATA_BITS-1:0]          q_payload,
    input  logic [SEQ_BITS-1:0]           q_ack,
    input  logic                          q_ck_ok,
    output logic                          q_pop,
    // results
    output logic                          done,
    output logic                          accepted,
    output logic                          window_full,
    output logic                          tx_valid,
    output logic [SEQ_BITS-1:0]           tx_seq,
    output logic [DATA_BITS-1:0]          tx_data,
    output logic                          timer_stop,
    output logic [SEQ_BITS-1:0]           stop_seq,
    output logic                          timer_start,
    output logic [SEQ_BITS-1:0]           start_seq
);

    import swsfr_pkg::*;

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = SLOT_W + 1;
    localparam int CW     = SEQ_BITS + 1;

    typedef enum logic {
        B_EXEC,
        B_READ
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [SEQ_BITS-1:0]  base_reg, base_next;
    logic [SEQ_BITS-1:0]  next_reg, next_next;
    logic [DUP_W-1:0]     dup_reg, dup_next;
    logic                 full_reg, full_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    logic                 done_reg, done_next;
    logic                 acc_reg, acc_next;
    logic                 txv_reg, txv_next;
    logic [SEQ_BITS-1:0]  txs_reg, txs_next;
    logic [DATA_BITS-1:0] txd_reg, txd_next;
    logic                 stp_reg, stp_next;
    logic [SEQ_BITS-1:0]  stps_reg, stps_next;
    logic                 sta_reg, sta_next;
    logic [SEQ_BITS-1:0]  stas_reg, stas_next;

    logic [SEQ_BITS-1:0]  outstanding;
    logic [SEQ_BITS-1:0]  ack_off;
    logic [CW-1:0]        eff_win;
    logic [LIMIT_W-1:0]   eff_lim;
    logic [DUP_W-1:0]     dup_inc;
    logic                 has_room;
    logic                 ack_ok;
    logic [SUM_W-1:0]     send_sum;
    logic [SUM_W-1:0]     slide_sum;
    logic [SLOT_W-1:0]    send_slot;
    logic [SLOT_W-1:0]    slide_slot;

    logic                 ram_we;
    logic                 ram_re;
    logic [DATA_BITS-1:0] ram_rdata;

    // Window and limit with out-of-range values clamped
    always_comb
    begin
        eff_win = CW'(cfg_window);
        if (cfg_window == '0)
        begin
            eff_win = CW'(1);
        end
        else if (CW'(cfg_window) > CW'(MAX_WINDOW))
        begin
            eff_win = CW'(MAX_WINDOW);
        end
        eff_lim = (cfg_limit < LIMIT_MIN) ? LIMIT_MIN : cfg_limit;
    end

    // Window distances from the base
    assign outstanding = next_reg - base_reg;
    assign ack_off     = q_ack - base_reg;
    assign has_room    = (CW'(outstanding) < eff_win);
    assign ack_ok      = q_ck_ok && (outstanding != '0) && (ack_off <= outstanding);
    assign dup_inc     = (dup_reg == DUP_MAX) ? DUP_MAX : dup_reg + DUP_W'(1);

    // Ring slots: both sums stay below twice the depth
    assign send_sum  = SUM_W'(slot_reg) + outstanding[SUM_W-1:0];
    assign slide_sum = SUM_W'(slot_reg) + ack_off[SUM_W-1:0];
    assign send_slot = (send_sum >= SUM_W'(MAX_WINDOW)) ?
                       SLOT_W'(send_sum - SUM_W'(MAX_WINDOW)) : SLOT_W'(send_sum);
    assign slide_slot = (slide_sum >= SUM_W'(MAX_WINDOW)) ?
                        SLOT_W'(slide_sum - SUM_W'(MAX_WINDOW)) : SLOT_W'(slide_sum);

    // Execute one queued word
    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        next_next  = next_reg;
        dup_next   = dup_reg;
        full_next  = full_reg;
        slot_next  = slot_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        txv_next   = txv_reg;
        txs_next   = txs_reg;
        txd_next   = txd_reg;
        stp_next   = stp_reg;
        stps_next  = stps_reg;
        sta_next   = sta_reg;
        stas_next  = stas_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        case (state_reg)
            B_EXEC:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    done_next = 1'b1;
                    acc_next  = 1'b0;
                    txv_next  = 1'b0;
                    txs_next  = '0;
                    txd_next  = '0;
                    stp_next  = 1'b0;
                    stps_next = '0;
                    sta_next  = 1'b0;
                    stas_next = '0;
                    case (q_op)
                        OP_SEND:
                        begin
                            if (has_room)
                            begin
                                ram_we    = 1'b1;
                                full_next = 1'b0;
                                acc_next  = 1'b1;
                                txv_next  = 1'b1;
                                txs_next  = next_reg;
                                txd_next  = q_payload;
                                if (outstanding == '0)
                                begin
                                    sta_next  = 1'b1;
                                    stas_next = next_reg;
                                end
                                next_next = next_reg + SEQ_BITS'(1);
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        OP_ACK:
                        begin
                            if (ack_ok)
                            begin
                                if (ack_off == '0)
                                begin
                                    // duplicate ack
                                    dup_next = dup_inc;
                                    if (dup_inc >= eff_lim)
                                    begin
                                        dup_next   = '0;
                                        ram_re     = 1'b1;
                                        done_next  = 1'b0;
                                        state_next = B_READ;
                                        txv_next   = 1'b1;
                                        txs_next   = base_reg;
                                        stp_next   = 1'b1;
                                        stps_next  = base_reg;
                                        sta_next   = 1'b1;
                                        stas_next  = base_reg;
                                    end
                                end
                                else
                                begin
                                    // new ack slides the window
                                    stp_next  = 1'b1;
                                    stps_next = base_reg;
                                    slot_next = slide_slot;
                                    base_next = q_ack;
                                    dup_next  = DUP_W'(1);
                                    if (q_ack != next_reg)
                                    begin
                                        sta_next  = 1'b1;
                                        stas_next = q_ack;
                                    end
                                end
                            end
                        end
                        OP_TIMEOUT:
                        begin
                            if (outstanding != '0)
                            begin
                                ram_re     = 1'b1;
                                done_next  = 1'b0;
                                state_next = B_READ;
                                txv_next   = 1'b1;
                                txs_next   = base_reg;
                                stp_next   = 1'b1;
                                stps_next  = base_reg;
                                sta_next   = 1'b1;
                                stas_next  = base_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_READ:
            begin
                // oldest payload arrives from the ring
                txd_next   = ram_rdata;
                done_next  = 1'b1;
                state_next = B_EXEC;
            end
            default:
            begin
                state_next = B_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_EXEC;
            base_reg  <= SEQ_BITS'(1);
            next_reg  <= SEQ_BITS'(1);
            dup_reg   <= '0;
            full_reg  <= 1'b0;
            slot_reg  <= '0;
            done_reg  <= 1'b0;
            acc_reg   <= 1'b0;
            txv_reg   <= 1'b0;
            txs_reg   <= '0;
            txd_reg   <= '0;
            stp_reg   <= 1'b0;
            stps_reg  <= '0;
            sta_reg   <= 1'b0;
            stas_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            next_reg  <= next_next;
            dup_reg   <= dup_next;
            full_reg  <= full_next;
            slot_reg  <= slot_next;
            done_reg  <= done_next;
            acc_reg   <= acc_next;
            txv_reg   <= txv_next;
            txs_reg   <= txs_next;
            txd_reg   <= txd_next;
            stp_reg   <= stp_next;
            stps_reg  <= stps_next;
            sta_reg   <= sta_next;
            stas_reg  <= stas_next;
        end
    end

    // Payload ring
    swsfr_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (MAX_WINDOW),
        .AW    (SLOT_W)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (send_slot),
        .wdata (q_payload),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign done        = done_reg;
    assign accepted    = acc_reg;
    assign window_full = full_reg;
    assign tx_valid    = txv_reg;
    assign tx_seq      = txs_reg;
    assign tx_data     = txd_reg;
    assign timer_stop  = stp_reg;
    assign stop_seq    = stps_reg;
    assign timer_start = sta_reg;
    assign start_seq   = stas_reg;

endmodule

>>> hw/rtl/sliding_window_sender_fast_retransmit.sv
`timescale 1ns / 1ps

// Sender side of a sliding-window transfer with cumulative acks and fast retransmit.
// Command channel: drive func/payload/ack_seq/ack_checksum_ok with start high; the
// word is taken at the edge where start is high and busy is low. func selects a
// send request, an ack arrival or a timer expiry; func 3 gives an empty result.
// Result channel: every command gives exactly one result word, shown for one cycle
// with done high. Fields that do not apply read zero; window_full always shows the
// refusal flag. The receiver cannot stall, so nothing is ever held back.
// done is registered after the word passes the front queue and the back end; a resend
// of the oldest packet adds the B_READ state, as the ring has a registered read port.
// busy stays high until done is shown, so commands never overlap. Timer start/stop
// are commands to an outside timer; the block does not count time. Reset: base and
// next sequence 1, duplicate count 0, flag clear, window 4, limit 4. The ring needs
// no clearing: only entries written by accepted sends are read. The user writes the
// APB registers (window_size at 0x0, dup_ack_limit at 0x4) only while idle; unchecked.

module sliding_window_sender_fast_retransmit #(
    parameter int MAX_WINDOW = swsfr_pkg::MAX_WINDOW_DEF,
    parameter int SEQ_BITS   = swsfr_pkg::SEQ_BITS_DEF,
    parameter int DATA_BITS  = swsfr_pkg::DATA_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           func,
    input  logic [DATA_BITS-1:0] payload,
    input  logic [SEQ_BITS-1:0]  ack_seq,
    input  logic                 ack_checksum_ok,
    // result channel
    output logic                 done,
    output logic                 accepted,
    output logic                 window_full,
    output logic                 tx_valid,
    output logic [SEQ_BITS-1:0]  tx_seq,
    output logic [DATA_BITS-1:0] tx_data,
    output logic                 timer_stop,
    output logic [SEQ_BITS-1:0]  stop_seq,
    output logic                 timer_start,
    output logic [SEQ_BITS-1:0]  start_seq
);

    import swsfr_pkg::*;

    logic [WIN_W-1:0]     window_reg, window_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic                 busy_reg, busy_next;
    logic                 cfg_wr;
    logic                 take;
    logic                 room;

    logic                 q_valid;
    op_t                  q_op;
    logic [DATA_BITS-1:0] q_payload;
    logic [SEQ_BITS-1:0]  q_ack;
    logic                 q_ck_ok;
    logic                 q_pop;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        window_next = window_reg;
        limit_next  = limit_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_WINDOW)
            begin
                window_next = pwdata[WIN_W-1:0];
            end
            else
            begin
                limit_next = pwdata[LIMIT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_DUP_LIMIT) ? 32'(limit_reg) : 32'(window_reg);

    // One command in flight at a time
    assign take = start && !busy_reg && room;
    always_comb
    begin
        busy_next = busy_reg;
        if (take)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end
    assign busy = busy_reg || !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RST;
            limit_reg  <= LIMIT_RST;
            busy_reg   <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            limit_reg  <= limit_next;
            busy_reg   <= busy_next;
        end
    end

    swsfr_front #(
        .SEQ_BITS  (SEQ_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .func            (func),
        .payload         (payload),
        .ack_seq         (ack_seq),
        .ack_checksum_ok (ack_checksum_ok),
        .room            (room),
        .q_valid         (q_valid),
        .q_op            (q_op),
        .q_payload       (q_payload),
        .q_ack           (q_ack),
        .q_ck_ok         (q_ck_ok),
        .q_pop           (q_pop)
    );

    swsfr_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_BITS   (SEQ_BITS),
        .DATA_BITS  (DATA_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_window  (window_reg),
        .cfg_limit   (limit_reg),
        .q_valid     (q_valid),
        .q_op        (q_op),
        .q_payload   (q_payload),
        .q_ack       (q_ack),
        .q_ck_ok     (q_ck_ok),
        .q_pop       (q_pop),
        .done        (done),
        .accepted    (accepted),
        .window_full (window_full),
        .tx_valid    (tx_valid),
        .tx_seq      (tx_seq),
        .tx_data     (tx_data),
        .timer_stop  (timer_stop),
        .stop_seq    (stop_seq),
        .timer_start (timer_start),
        .start_seq   (start_seq)
    );

endmodule
